// ===== rtl/bmhq_pkg.sv =====
// Shared constants, types and store command struct for the binary max-heap queue.
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [31:0] key_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef struct packed {
        logic we;
        idx_t waddr;
        key_t wdata;
        logic re;
        idx_t raddr_a;
        idx_t raddr_b;
    } store_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bmhq_if.sv =====
// Valid/ready channel interfaces for heap queue requests and responses.
`default_nettype none

interface bmhq_req_if
    import bmhq_pkg::*;
    ();
    logic valid;
    logic ready;
    logic func;
    key_t value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface bmhq_rsp_if
    import bmhq_pkg::*;
    ();
    logic valid;
    logic ready;
    logic ok;
    key_t max_value;
    cnt_t occupancy;

    modport source (output valid, output ok, output max_value, output occupancy, input ready);
    modport sink   (input valid, input ok, input max_value, input occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/bmhq_store.sv =====
// Heap key store: one write port, two registered read ports.
`default_nettype none

module bmhq_store
    import bmhq_pkg::*;
(
    input  wire logic       clk,
    input  wire store_cmd_t cmd,
    output key_t            rd_a_reg,
    output key_t            rd_b_reg
);

    key_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        if (cmd.re)
        begin
            rd_a_reg <= mem[cmd.raddr_a];
            rd_b_reg <= mem[cmd.raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/binary_max_heap_queue.sv =====
// Top level of the bounded binary max-heap priority queue.
//
//  channel | dir | payload                            | transfer
//  req     | in  | func, value                        | valid && ready
//  rsp     | out | ok, max_value, occupancy           | valid && ready
//
//  Insert: the key climbs from the new last slot; each level is a read (ST_UP_RD) and
//  a compare-and-write (ST_UP_CMP) that moves a smaller parent down into the hole.
//  Remove: ST_RM_RD reads root and last entry, ST_RM_LOAD latches them, then the key
//  descends through ST_DN_RD and ST_DN_CMP; a rejected transaction goes to ST_DONE.
//  The split into read and write steps follows from the store's registered read ports.
//  Reset clears the entry count and control state; the key store is not cleared.
//  One transaction is in work at a time; a held response stalls the next one in ST_DONE.
`default_nettype none

module binary_max_heap_queue
    import bmhq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmhq_req_if.sink    req,
    bmhq_rsp_if.source  rsp
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_UP_RD   = 3'd1;
    localparam logic [2:0] ST_UP_CMP  = 3'd2;
    localparam logic [2:0] ST_RM_RD   = 3'd3;
    localparam logic [2:0] ST_RM_LOAD = 3'd4;
    localparam logic [2:0] ST_DN_RD   = 3'd5;
    localparam logic [2:0] ST_DN_CMP  = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0] state_reg, state_next;
    cnt_t       count_reg, count_next;
    idx_t       pos_reg, pos_next;
    key_t       key_reg, key_next;
    logic       res_ok_reg, res_ok_next;
    key_t       res_max_reg, res_max_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_ok_reg;
    key_t       out_max_reg;
    cnt_t       out_occ_reg;
    logic       out_load;

    store_cmd_t cmd;
    key_t       rd_a, rd_b;

    idx_t           up_addr;
    logic [IDX_W+1:0] lc_w, rc_w, cnt_w;
    logic           is_leaf, rc_in, pick_right;
    key_t           pick_val;
    idx_t           pick_idx;

    bmhq_store u_store (
        .clk      (clk),
        .cmd      (cmd),
        .rd_a_reg (rd_a),
        .rd_b_reg (rd_b)
    );

    assign up_addr    = idx_t'((pos_reg - idx_t'(1)) >> 1);
    assign lc_w       = {1'b0, pos_reg, 1'b1};
    assign rc_w       = lc_w + (IDX_W+2)'(1);
    assign cnt_w      = (IDX_W+2)'(count_reg);
    assign is_leaf    = (lc_w >= cnt_w);
    assign rc_in      = (rc_w < cnt_w);
    assign pick_right = rc_in && (rd_b > rd_a);
    assign pick_val   = pick_right ? rd_b : rd_a;
    assign pick_idx   = pick_right ? rc_w[IDX_W-1:0] : lc_w[IDX_W-1:0];

    assign req.ready  = (state_reg == ST_IDLE);
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        res_ok_next  = res_ok_reg;
        res_max_next = res_max_reg;
        cmd          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_ok_next  = 1'b0;
                    res_max_next = '0;
                    pos_next     = '0;
                    state_next   = ST_DONE;
                    if (req.func == FUNC_INSERT)
                    begin
                        if (count_reg != cnt_t'(CAPACITY))
                        begin
                            key_next    = req.value;
                            pos_next    = count_reg[IDX_W-1:0];
                            count_next  = count_reg + cnt_t'(1);
                            res_ok_next = 1'b1;
                            state_next  = ST_UP_RD;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        count_next  = count_reg - cnt_t'(1);
                        res_ok_next = 1'b1;
                        state_next  = ST_RM_RD;
                    end
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    cmd.we     = 1'b1;
                    cmd.waddr  = pos_reg;
                    cmd.wdata  = key_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.re      = 1'b1;
                    cmd.raddr_a = up_addr;
                    state_next  = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                cmd.we    = 1'b1;
                cmd.waddr = pos_reg;
                if (key_reg > rd_a)
                begin
                    // parent moves down into the hole
                    cmd.wdata  = rd_a;
                    pos_next   = up_addr;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    cmd.wdata  = key_reg;
                    state_next = ST_DONE;
                end
            end
            ST_RM_RD:
            begin
                cmd.re      = 1'b1;
                cmd.raddr_a = '0;
                cmd.raddr_b = count_reg[IDX_W-1:0];
                state_next  = ST_RM_LOAD;
            end
            ST_RM_LOAD:
            begin
                res_max_next = rd_a;
                key_next     = rd_b;
                state_next   = ST_DN_RD;
            end
            ST_DN_RD:
            begin
                if (is_leaf)
                begin
                    cmd.we     = 1'b1;
                    cmd.waddr  = pos_reg;
                    cmd.wdata  = key_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.re      = 1'b1;
                    cmd.raddr_a = lc_w[IDX_W-1:0];
                    cmd.raddr_b = rc_w[IDX_W-1:0];
                    state_next  = ST_DN_CMP;
                end
            end
            ST_DN_CMP:
            begin
                cmd.we    = 1'b1;
                cmd.waddr = pos_reg;
                if (pick_val > key_reg)
                begin
                    // larger child moves up into the hole
                    cmd.wdata  = pick_val;
                    pos_next   = pick_idx;
                    state_next = ST_DN_RD;
                end
                else
                begin
                    cmd.wdata  = key_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        res_ok_reg  <= res_ok_next;
        res_max_reg <= res_max_next;
        if (out_load)
        begin
            out_ok_reg  <= res_ok_reg;
            out_max_reg <= res_max_reg;
            out_occ_reg <= count_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.ok        = out_ok_reg;
    assign rsp.max_value = out_max_reg;
    assign rsp.occupancy = out_occ_reg;

endmodule

`default_nettype wire

// ===== rtl/bmhq_checker.sv =====
// Port-level assertions for the heap queue, bound to the top level.
`default_nettype none

module bmhq_checker
    import bmhq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic rsp_ok,
    input wire key_t rsp_max_value,
    input wire cnt_t rsp_occupancy
);

    cnt_t             occ_seen_reg;
    logic [CNT_W:0]   occ_w, seen_w;

    assign occ_w  = {1'b0, rsp_occupancy};
    assign seen_w = {1'b0, occ_seen_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_seen_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            occ_seen_reg <= rsp_occupancy;
        end
    end

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_max_value == '0)
        else $error("rejected transaction carries a non-zero key");

    a_fail_edge: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> occ_w == '0 || occ_w == (CNT_W+1)'(CAPACITY))
        else $error("rejection while neither empty nor full");

    a_ok_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ok |-> occ_w == seen_w + 1'b1 || occ_w + 1'b1 == seen_w)
        else $error("occupancy did not move by one on success");

    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> occ_w == seen_w)
        else $error("occupancy moved on a rejected transaction");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_occupancy))
        else $error("stalled response changed");

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_ok        (rsp.ok),
    .rsp_max_value (rsp.max_value),
    .rsp_occupancy (rsp.occupancy)
);

`default_nettype wire

// ===== tb/binary_max_heap_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the binary max-heap queue under directed and random traffic.
module binary_max_heap_queue_tb;
    import bmhq_pkg::*;

    localparam int     HOLD_CYCLES  = 300;
    localparam int     RANDOM_ITEMS = 1680;
    localparam int     TAIL_CYCLES  = 40;
    localparam longint CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic       func;
        key_t       value;
        logic [3:0] gap;
        logic       drain;
    } heap_op_t;

    typedef struct packed {
        logic ok;
        key_t max_value;
        cnt_t occupancy;
    } heap_outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bmhq_req_if req ();
    bmhq_rsp_if rsp ();

    binary_max_heap_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    heap_op_t      op_queue [$];
    heap_outcome_t predicted_outcomes [$];
    key_t          shadow_heap [CAPACITY];
    int            shadow_count;
    int            mismatches;
    longint        cycle_count;

    heap_op_t      next_op;
    int            gap_left;
    heap_outcome_t want;
    int            stall_left;
    int            stall_next;
    int            rsp_count;
    logic          rx_fast;

    always #5 clk = ~clk;

    function automatic void swap_entries(int a, int b);
        key_t tmp;
        tmp            = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = tmp;
    endfunction

    // Applies one operation to the shadow heap and returns the response it should produce.
    function automatic heap_outcome_t heap_apply(logic func, key_t value);
        heap_outcome_t res;
        int            pos;
        int            parent;
        int            pick;
        logic          settled;
        res = '0;
        if (func == FUNC_INSERT)
        begin
            if (shadow_count < CAPACITY)
            begin
                shadow_heap[shadow_count] = value;
                pos     = shadow_count;
                settled = 1'b0;
                while (pos > 0 && !settled)
                begin
                    parent = (pos - 1) / 2;
                    if (shadow_heap[pos] > shadow_heap[parent])
                    begin
                        swap_entries(pos, parent);
                        pos = parent;
                    end
                    else
                        settled = 1'b1;
                end
                shadow_count++;
                res.ok = 1'b1;
            end
        end
        else if (shadow_count > 0)
        begin
            res.max_value = shadow_heap[0];
            shadow_count--;
            shadow_heap[0] = shadow_heap[shadow_count];
            pos     = 0;
            settled = 1'b0;
            while (!settled)
            begin
                if (2 * pos + 1 >= shadow_count)
                    settled = 1'b1;
                else
                begin
                    pick = 2 * pos + 1;
                    // right child only when strictly greater
                    if (pick + 1 < shadow_count && shadow_heap[pick + 1] > shadow_heap[pick])
                        pick = pick + 1;
                    if (shadow_heap[pick] > shadow_heap[pos])
                    begin
                        swap_entries(pos, pick);
                        pos = pick;
                    end
                    else
                        settled = 1'b1;
                end
            end
            res.ok = 1'b1;
        end
        res.occupancy = cnt_t'(shadow_count);
        return res;
    endfunction

    function automatic key_t draw_key();
        case ($urandom_range(0, 3))
            0: return key_t'(int'($urandom_range(0, 8)) - 4);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return 32'shFFFF_FFFF;
                endcase
            end
            default: return key_t'($urandom());
        endcase
    endfunction

    task automatic queue_op(logic func, key_t value, int gap, logic drain);
        heap_op_t op;
        op.func  = func;
        op.value = value;
        op.gap   = gap[3:0];
        op.drain = drain;
        op_queue.push_back(op);
    endtask

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.func  <= FUNC_INSERT;
            req.value <= '0;
            gap_left  <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                predicted_outcomes.push_back(heap_apply(req.func, req.value));
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    req.valid <= 1'b0;
                    gap_left  <= gap_left - 1;
                end
                else if (op_queue.size() > 0 &&
                         !(op_queue[0].drain && predicted_outcomes.size() > 0))
                begin
                    next_op    = op_queue.pop_front();
                    req.valid <= 1'b1;
                    req.func  <= next_op.func;
                    req.value <= next_op.value;
                    gap_left  <= next_op.gap;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // response monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            stall_left <= 0;
            rsp_count  <= 0;
            rx_fast    <= 1'b0;
        end
        else
        begin
            stall_next = (stall_left > 0) ? stall_left - 1 : 0;
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_outcomes.size() == 0)
                    note_mismatch($sformatf(
                        "unexpected transaction: ok=%0b max_value=%0d occupancy=%0d",
                        rsp.ok, rsp.max_value, rsp.occupancy));
                else
                begin
                    want = predicted_outcomes.pop_front();
                    if (rsp.ok !== want.ok || rsp.max_value !== want.max_value ||
                        rsp.occupancy !== want.occupancy)
                        note_mismatch($sformatf(
                            "transaction %0d: expected ok=%0b max_value=%0d occupancy=%0d, got ok=%0b max_value=%0d occupancy=%0d",
                            rsp_count, want.ok, want.max_value, want.occupancy,
                            rsp.ok, rsp.max_value, rsp.occupancy));
                end
                rsp_count <= rsp_count + 1;
                if (rsp_count % 64 == 63)
                    rx_fast <= ($urandom_range(0, 2) == 0);
                // long hold so the queue backs up into the request side
                if (rsp_count == 200 || rsp_count == 1000)
                    stall_next = HOLD_CYCLES;
                else
                    stall_next = rx_fast ? 0 : $urandom_range(0, 14);
            end
            stall_left <= stall_next;
            rsp.ready  <= (stall_next == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int   produced;
        int   phase_len;
        int   insert_pct;
        logic fast;
        logic pause;
        logic first_phase;

        req.valid    = 1'b0;
        req.func     = FUNC_INSERT;
        req.value    = '0;
        rsp.ready    = 1'b0;
        shadow_count = 0;
        mismatches   = 0;
        cycle_count  = 0;

        // empty remove, fill with extremes and equal keys, overfill, then drain a few
        queue_op(FUNC_REMOVE, 32'sh0000_0000, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh7FFF_FFFF, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh8000_0000, 3, 1'b0);
        queue_op(FUNC_INSERT, 32'sh0000_0000, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'shFFFF_FFFF, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh0000_0001, 1, 1'b0);
        queue_op(FUNC_INSERT, 32'sh0000_0005, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh0000_0005, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh0000_0005, 7, 1'b0);
        queue_op(FUNC_INSERT, 32'shFFFF_FFFB, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh7FFF_FFFE, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh8000_0001, 2, 1'b0);
        queue_op(FUNC_INSERT, 32'sh0000_0064, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'shFFFF_FF9C, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh0000_0005, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh0000_0000, 4, 1'b0);
        queue_op(FUNC_INSERT, 32'sh7FFF_FFFF, 0, 1'b0);
        queue_op(FUNC_INSERT, 32'sh5555_AAAA, 0, 1'b0);
        queue_op(FUNC_REMOVE, 32'shFFFF_FFFF, 0, 1'b0);
        queue_op(FUNC_REMOVE, 32'sh0000_0000, 9, 1'b0);
        queue_op(FUNC_REMOVE, 32'shAAAA_5555, 0, 1'b0);
        queue_op(FUNC_REMOVE, 32'sh0000_0000, 0, 1'b0);

        // random phases: insert-heavy, remove-heavy and balanced
        produced    = 0;
        first_phase = 1'b1;
        while (produced < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0: insert_pct = 80;
                1: insert_pct = 20;
                default: insert_pct = 50;
            endcase
            fast  = ($urandom_range(0, 3) == 0);
            pause = first_phase || ($urandom_range(0, 5) == 0);
            for (int i = 0; i < phase_len; i++)
                queue_op(($urandom_range(1, 100) <= insert_pct) ? FUNC_INSERT : FUNC_REMOVE,
                         draw_key(), fast ? 0 : $urandom_range(0, 14), pause && i == 0);
            produced    += phase_len;
            first_phase  = 1'b0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() > 0 || req.valid || predicted_outcomes.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && predicted_outcomes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
